>>> hdl/bod_pkg.sv
// Package for the bounded overwrite deque: operation codes, field widths and defaults.
package bod_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CAP_RESET     = 16;

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int CAP_W   = 5;
  localparam int COUNT_W = 5;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_READ       = 3'd4
  } kind_e;

endpackage

>>> hdl/bounded_overwrite_deque.sv
// Bounded double-ended queue of words with overwrite on full and a capacity register.
// Two register stages: an accepted word enters the read stage, then the output register.
// Throughput: one word per cycle without back pressure; a capacity write holds the input off.
// The ring store takes one write or one read per item, and its read data is registered.
// Reset clears head pointer, count, stage valids and sets capacity to min(16, DEPTH).
// The ring store itself is not cleared; only pushed entries are ever read.
module bounded_overwrite_deque #(
  parameter int DEPTH = bod_pkg::DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Capacity register write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bod_pkg::CAP_W-1:0]      cfg_data_i,
  // Input words.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: value [31:0], position [35:32], zero fill [39:36].
  input  logic [bod_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: kind [2:0].
  input  logic [bod_pkg::KIND_W-1:0]     s_axis_tuser_i,
  // Result words.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: read_data [31:0], count [36:32], error [37], zero fill [39:38].
  output logic [bod_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW     = $clog2(DEPTH + 1);
  localparam int SW       = $clog2(DEPTH + 16) + 1;
  localparam int EW       = (CNTW > bod_pkg::CAP_W) ? CNTW : bod_pkg::CAP_W;
  localparam int CapReset = (bod_pkg::CAP_RESET > DEPTH) ? DEPTH : bod_pkg::CAP_RESET;
  localparam int VW       = bod_pkg::VALUE_W;
  localparam int PW       = bod_pkg::POS_W;
  localparam int OW       = bod_pkg::COUNT_W;

  // Ring position head + offset, reduced modulo DEPTH; offset never reaches 2*DEPTH where the result is used.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + off;
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0]   head_q, head_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [CNTW-1:0] cap_q, cap_d;

  logic [VW-1:0] mem_q [DEPTH];
  logic [VW-1:0] rd_q;

  logic          s1_valid_q;
  logic          s1_rd_q;
  logic          s1_err_q;
  logic [OW-1:0] s1_count_q;

  logic                           m_valid_q;
  logic [bod_pkg::OUT_DATA_W-1:0] m_data_q;

  logic          in_acc, cfg_acc, s1_adv;
  logic [VW-1:0] in_value;
  logic [PW-1:0] in_pos;
  logic          wr_en, rd_en, err;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [OW-1:0] count_out;
  logic [CNTW+OW-1:0] count_ext;
  logic [EW-1:0] cfg_ext, cfg_sat;
  logic [CNTW-1:0] count_clamp;

  assign in_value = s_axis_tdata_i[VW-1:0];
  assign in_pos   = s_axis_tdata_i[VW+PW-1:VW];

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s1_adv          = s1_valid_q && (!m_valid_q || m_axis_tready_i);
  // A capacity write takes the cycle, so no word is taken alongside it.
  assign s_axis_tready_o = (!s1_valid_q || s1_adv) && !cfg_valid_i;
  assign cfg_ready_o     = 1'b1;
  assign cfg_acc         = cfg_valid_i && cfg_ready_o;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = wrap(head_q, SW'(count_q));
    rd_en   = 1'b0;
    rd_addr = wrap(head_q, SW'(in_pos));
    err     = 1'b0;
    case (bod_pkg::kind_e'(s_axis_tuser_i))
      bod_pkg::KIND_PUSH_FRONT: begin
        head_d  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
        wr_en   = 1'b1;
        wr_addr = head_d;
        if (count_q < cap_q) begin
          count_d = count_q + CNTW'(1);
        end
      end
      bod_pkg::KIND_PUSH_BACK: begin
        wr_en = 1'b1;
        if (count_q < cap_q) begin
          count_d = count_q + CNTW'(1);
        end else begin
          // Full: the front entry falls off.
          head_d = wrap(head_q, SW'(1));
        end
      end
      bod_pkg::KIND_POP_FRONT: begin
        if (count_q == '0) begin
          err = 1'b1;
        end else begin
          head_d  = wrap(head_q, SW'(1));
          count_d = count_q - CNTW'(1);
        end
      end
      bod_pkg::KIND_POP_BACK: begin
        if (count_q == '0) begin
          err = 1'b1;
        end else begin
          count_d = count_q - CNTW'(1);
        end
      end
      bod_pkg::KIND_READ: begin
        if (SW'(in_pos) < SW'(count_q)) begin
          rd_en = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign count_ext = {{OW{1'b0}}, count_d};
  assign count_out = count_ext[OW-1:0];

  // Capacity write saturates to the range one to DEPTH.
  always_comb begin
    cfg_ext = EW'(cfg_data_i);
    cfg_sat = cfg_ext;
    if (cfg_ext == '0) begin
      cfg_sat = EW'(1);
    end else if (cfg_ext > EW'(DEPTH)) begin
      cfg_sat = EW'(DEPTH);
    end
    cap_d       = cfg_sat[CNTW-1:0];
    count_clamp = (count_q > cap_d) ? cap_d : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      cap_q   <= CNTW'(CapReset);
    end else if (cfg_acc) begin
      cap_q   <= cap_d;
      count_q <= count_clamp;
    end else if (in_acc) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && wr_en) begin
      mem_q[wr_addr] <= in_value;
    end
    if (in_acc && rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_rd_q    <= rd_en;
      s1_err_q   <= err;
      s1_count_q <= count_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= {2'b00, s1_err_q, s1_count_q, (s1_rd_q ? rd_q : {VW{1'b0}})};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_count_in_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("entry count exceeds capacity");

  a_cap_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= CNTW'(DEPTH)))
    else $error("capacity outside one to DEPTH");

  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted word did not reach the read stage");

  a_error_zero_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[VW+OW]) |-> (m_data_q[VW-1:0] == '0))
    else $error("error result carries nonzero read data");

  a_stall_holds_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && m_valid_q && !m_axis_tready_i) |=> s1_valid_q)
    else $error("read stage dropped a word under back pressure");

endmodule

>>> sim/bounded_overwrite_deque_tb.sv
// Self-checking testbench for the bounded overwrite deque: directed and random stream traffic.
module bounded_overwrite_deque_tb;

  localparam int RING_DEPTH = bod_pkg::DEPTH_DEFAULT;
  localparam int KIND_W     = bod_pkg::KIND_W;
  localparam int VALUE_W    = bod_pkg::VALUE_W;
  localparam int POS_W      = bod_pkg::POS_W;
  localparam int CAP_W      = bod_pkg::CAP_W;
  localparam int COUNT_W    = bod_pkg::COUNT_W;
  localparam int IN_DATA_W  = bod_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = bod_pkg::OUT_DATA_W;
  localparam logic [KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0] read_data;
    logic [COUNT_W-1:0] count;
    logic               error;
  } deque_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CAP_W-1:0]      cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [KIND_W-1:0]     s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Mirror of the deque contents, updated as each word is accepted.
  logic [VALUE_W-1:0] model_ring [RING_DEPTH];
  int                 model_head;
  int                 model_count;
  int                 model_capacity;

  deque_result_t predicted_results[$];
  int            failures;
  bit            sender_gaps_on;
  bit            sink_gaps_on;
  int            sink_hold_request;

  bounded_overwrite_deque u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("[bounded_overwrite_deque] ERROR");
    $finish;
  end

  function automatic deque_result_t predict_deque_op(logic [KIND_W-1:0] kind,
                                                     logic [VALUE_W-1:0] value,
                                                     logic [POS_W-1:0] pos);
    deque_result_t res;
    res = '0;
    case (kind)
      bod_pkg::KIND_PUSH_FRONT: begin
        model_head = (model_head + RING_DEPTH - 1) % RING_DEPTH;
        model_ring[model_head] = value;
        if (model_count < model_capacity) model_count++;
      end
      bod_pkg::KIND_PUSH_BACK: begin
        model_ring[(model_head + model_count) % RING_DEPTH] = value;
        // A full queue loses its front entry instead of growing.
        if (model_count < model_capacity) model_count++;
        else model_head = (model_head + 1) % RING_DEPTH;
      end
      bod_pkg::KIND_POP_FRONT: begin
        if (model_count == 0) begin
          res.error = 1'b1;
        end else begin
          model_head = (model_head + 1) % RING_DEPTH;
          model_count--;
        end
      end
      bod_pkg::KIND_POP_BACK: begin
        if (model_count == 0) res.error = 1'b1;
        else model_count--;
      end
      bod_pkg::KIND_READ: begin
        if (int'(pos) < model_count) res.read_data = model_ring[(model_head + pos) % RING_DEPTH];
        else res.error = 1'b1;
      end
      default: ;
    endcase
    res.count = COUNT_W'(model_count);
    return res;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Leaves tvalid high so that back-to-back words go out without a gap.
  task automatic send_word(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                           logic [POS_W-1:0] pos);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {{(IN_DATA_W - VALUE_W - POS_W){1'b0}}, pos, value};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted_results.insert(predicted_results.size(), predict_deque_op(kind, value, pos));
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_for_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    model_capacity = value;
    if (model_capacity < 1) model_capacity = 1;
    if (model_capacity > RING_DEPTH) model_capacity = RING_DEPTH;
    if (model_count > model_capacity) model_count = model_capacity;
  endtask

  task automatic send_random_item(int push_pct);
    int                 roll;
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos;
    roll = $urandom_range(0, 99);
    pos  = POS_W'($urandom);
    if (roll < push_pct) begin
      kind = $urandom_range(0, 1) ? bod_pkg::KIND_PUSH_FRONT : bod_pkg::KIND_PUSH_BACK;
    end else if (roll < push_pct + 25) begin
      kind = $urandom_range(0, 1) ? bod_pkg::KIND_POP_FRONT : bod_pkg::KIND_POP_BACK;
    end else if (roll < 97) begin
      kind = bod_pkg::KIND_READ;
      // Mostly in-range reads, so stored words actually get compared.
      if (model_count > 0 && $urandom_range(0, 9) < 8)
        pos = POS_W'($urandom_range(0, model_count - 1));
    end else begin
      kind = KIND_W'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    end
    send_word(kind, pick_value(), pos);
    if (sender_gaps_on && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 19));
  endtask

  task automatic test_empty_queue();
    send_word(bod_pkg::KIND_POP_FRONT, $urandom, POS_W'($urandom));
    send_word(bod_pkg::KIND_POP_BACK, $urandom, POS_W'($urandom));
    send_word(bod_pkg::KIND_READ, $urandom, '0);
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
      send_word(KIND_W'(k), $urandom, POS_W'($urandom));
  endtask

  task automatic test_push_read_pop();
    send_word(bod_pkg::KIND_PUSH_FRONT, 32'h7fff_ffff, '0);
    send_word(bod_pkg::KIND_PUSH_BACK, 32'h8000_0000, '1);
    send_word(bod_pkg::KIND_PUSH_FRONT, 32'hffff_ffff, '0);
    send_word(bod_pkg::KIND_PUSH_BACK, 32'h0000_0000, '1);
    send_word(bod_pkg::KIND_READ, $urandom, 4'd0);
    send_word(bod_pkg::KIND_READ, $urandom, 4'd3);
    // Index equal to the count is already out of range.
    send_word(bod_pkg::KIND_READ, $urandom, 4'd4);
    send_word(bod_pkg::KIND_READ, $urandom, 4'd15);
    send_word(bod_pkg::KIND_POP_FRONT, $urandom, '0);
    send_word(bod_pkg::KIND_POP_BACK, $urandom, '0);
    send_word(bod_pkg::KIND_READ, $urandom, 4'd0);
  endtask

  task automatic test_capacity_saturation();
    // Zero saturates to one and drops the back entry.
    write_capacity(5'd0);
    send_word(bod_pkg::KIND_PUSH_BACK, 32'h1234_5678, '0);
    send_word(bod_pkg::KIND_READ, $urandom, 4'd0);
    send_word(bod_pkg::KIND_PUSH_FRONT, 32'hcafe_f00d, '0);
    send_word(bod_pkg::KIND_READ, $urandom, 4'd0);
    write_capacity(5'd31);
  endtask

  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [8];
    int               bias [8];
    caps = '{5'd16, 5'd3, 5'd17, 5'd1, 5'd12, 5'd0, 5'd31, CAP_W'($urandom)};
    bias = '{70, 45, 50, 40, 65, 45, 35, 50};
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      repeat (55) send_random_item(bias[p]);
    end
  endtask

  task automatic test_backpressure();
    write_capacity(5'd16);
    sender_gaps_on    = 1'b0;
    sink_hold_request = 60;
    repeat (40) send_random_item(60);
    wait_for_results();
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_final_stream();
    sender_gaps_on = 1'b0;
    sink_gaps_on   = 1'b0;
    write_capacity(CAP_W'($urandom_range(1, 16)));
    repeat (40) send_random_item(50);
  endtask

  // Receiver: random stalls, plus a long hold when a test asks for one.
  initial begin
    int hold;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_request != 0) begin
        hold = sink_hold_request;
        sink_hold_request = 0;
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_deque_results
    deque_result_t exp_res;
    deque_result_t got_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_res = '{read_data: m_axis_tdata_o[31:0], count: m_axis_tdata_o[36:32],
                  error: m_axis_tdata_o[37]};
      if (predicted_results.size() == 0) begin
        $error("unexpected result word: data %h", m_axis_tdata_o);
        failures++;
      end else begin
        exp_res = predicted_results.pop_front();
        if (got_res.read_data !== exp_res.read_data) begin
          $error("read_data: expected %h, actual %h", exp_res.read_data, got_res.read_data);
          failures++;
        end
        if (got_res.count !== exp_res.count) begin
          $error("count: expected %0d, actual %0d", exp_res.count, got_res.count);
          failures++;
        end
        if (got_res.error !== exp_res.error) begin
          $error("error: expected %0d, actual %0d", exp_res.error, got_res.error);
          failures++;
        end
      end
    end
  end

  initial begin
    failures          = 0;
    sender_gaps_on    = 1'b1;
    sink_gaps_on      = 1'b1;
    sink_hold_request = 0;
    model_head        = 0;
    model_count       = 0;
    model_capacity    = (bod_pkg::CAP_RESET > RING_DEPTH) ? RING_DEPTH : bod_pkg::CAP_RESET;
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_push_read_pop();
    test_capacity_saturation();
    test_random_traffic();
    test_backpressure();
    test_final_stream();

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("[bounded_overwrite_deque] OK");
    end else begin
      $display("[bounded_overwrite_deque] ERROR");
    end
    $finish;
  end

endmodule

>>> bounded_overwrite_deque.f
hdl/bod_pkg.sv
hdl/bounded_overwrite_deque.sv
sim/bounded_overwrite_deque_tb.sv
